FILE: rtl/core/pbe_pkg.sv
// Shared constants, edge table and types for the plane/box edge intersection block.
// Has no dependencies. Every other file in rtl/core uses it.
package pbe_pkg;

  localparam int CW         = 32;               // Q16.16 coordinate width
  localparam int NW         = 16;               // Q2.14 normal component width
  localparam int PW         = CW + NW;          // one exact product
  localparam int NUM_W      = CW + NW + 3;      // d and the edge numerator
  localparam int DIV_STEPS  = 4;                // quotient bits per divider stage
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QW         = DIV_STAGES * DIV_STEPS;
  localparam int EW         = 4;

  localparam logic [EW-1:0] LAST_EDGE = EW'(11);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Axis along which an edge runs.
  function automatic logic [1:0] edge_free(input logic [EW-1:0] e);
    logic [1:0] f;
    unique case (e)
      4'd0, 4'd2, 4'd4, 4'd6: f = AXIS_X;
      4'd1, 4'd3, 4'd5, 4'd7: f = AXIS_Y;
      default:                f = AXIS_Z;
    endcase
    return f;
  endfunction

  // Corner select per axis as {z, y, x}; a set bit picks the high corner.
  function automatic logic [2:0] edge_sel(input logic [EW-1:0] e);
    logic [2:0] s;
    unique case (e)
      4'd1, 4'd9:  s = 3'b001;
      4'd2, 4'd10: s = 3'b010;
      4'd4, 4'd7:  s = 3'b100;
      4'd5:        s = 3'b101;
      4'd6:        s = 3'b110;
      4'd11:       s = 3'b011;
      default:     s = 3'b000;
    endcase
    return s;
  endfunction

  // Per-edge data that rides along the divider pipeline.
  typedef struct packed {
    logic                 item_end;
    logic                 skip;
    logic                 neg;
    logic [EW-1:0]        edge_id;
    logic [1:0]           free;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
    logic signed [CW-1:0] lo_f;
    logic signed [CW-1:0] hi_f;
  } tag_t;

  // One tested edge after the range check.
  typedef struct packed {
    logic                 hit;
    logic                 item_end;
    logic [EW-1:0]        edge_id;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } res_t;

endpackage

FILE: rtl/core/pbe_in_if.sv
// Input channel: plane normal, point on the plane and box corners, with valid/ready.
// Depends on pbe_pkg for field widths.
interface pbe_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [pbe_pkg::NW-1:0] normal_x;
  logic signed [pbe_pkg::NW-1:0] normal_y;
  logic signed [pbe_pkg::NW-1:0] normal_z;
  logic signed [pbe_pkg::CW-1:0] point_x;
  logic signed [pbe_pkg::CW-1:0] point_y;
  logic signed [pbe_pkg::CW-1:0] point_z;
  logic signed [pbe_pkg::CW-1:0] box_lo_x;
  logic signed [pbe_pkg::CW-1:0] box_lo_y;
  logic signed [pbe_pkg::CW-1:0] box_lo_z;
  logic signed [pbe_pkg::CW-1:0] box_hi_x;
  logic signed [pbe_pkg::CW-1:0] box_hi_y;
  logic signed [pbe_pkg::CW-1:0] box_hi_z;

  modport source (output valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                output ready);
endinterface

FILE: rtl/core/pbe_out_if.sv
// Result channel: intersection point, edge number and flags, with valid/ready.
// Depends on pbe_pkg for field widths.
interface pbe_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pbe_pkg::CW-1:0] hit_x;
  logic signed [pbe_pkg::CW-1:0] hit_y;
  logic signed [pbe_pkg::CW-1:0] hit_z;
  logic [pbe_pkg::EW-1:0]        edge_index;
  logic                          empty_res;
  logic                          last;

  modport source (output valid, hit_x, hit_y, hit_z, edge_index, empty_res, last,
                  input ready);
  modport sink (input valid, hit_x, hit_y, hit_z, edge_index, empty_res, last,
                output ready);
endinterface

FILE: rtl/core/pbe_div.sv
// Pipelined unsigned restoring divider, DIV_STEPS quotient bits per stage.
// Depends on pbe_pkg; the tag travels alongside each dividend.
module pbe_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [pbe_pkg::QW-1:0] in_num,
  input  logic [pbe_pkg::NW-1:0] in_den,
  input  pbe_pkg::tag_t         in_tag,
  output logic                  out_valid,
  output logic [pbe_pkg::QW-1:0] out_quot,
  output pbe_pkg::tag_t         out_tag
);

  localparam int NS = pbe_pkg::DIV_STAGES;
  localparam int NW = pbe_pkg::NW;
  localparam int QW = pbe_pkg::QW;

  logic              valid_r [NS];
  logic [QW-1:0]     quo_r   [NS];
  pbe_pkg::tag_t     tag_r   [NS];
  logic [NW-1:0]     rem_r   [NS-1];
  logic [NW-1:0]     den_r   [NS-1];
  logic [NW-1:0]     rem_nxt [NS];
  logic [QW-1:0]     quo_nxt [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic          v_in;
    logic [NW-1:0] r_in;
    logic [NW-1:0] d_in;
    logic [QW-1:0] a_in;
    pbe_pkg::tag_t t_in;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign d_in = in_den;
      assign a_in = in_num;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = valid_r[s-1];
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign a_in = quo_r[s-1];
      assign t_in = tag_r[s-1];
    end

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin : step
      logic [NW:0]   t;
      logic [NW-1:0] r;
      logic [QW-1:0] a;
      r = r_in;
      a = a_in;
      for (int k = 0; k < pbe_pkg::DIV_STEPS; k++) begin
        t = {r, a[QW-1]};
        a = {a[QW-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t    = t - {1'b0, d_in};
          a[0] = 1'b1;
        end
        r = t[NW-1:0];
      end
      rem_nxt[s] = r;
      quo_nxt[s] = a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_nxt[s];
        tag_r[s] <= t_in;
      end
    end

    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt[s];
          den_r[s] <= d_in;
        end
      end
    end
  end

  assign out_valid = valid_r[NS-1];
  assign out_quot  = quo_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

FILE: rtl/core/plane_box_edge_intersect.sv
// Top level of the plane/box edge intersection block.
// Depends on pbe_pkg, pbe_in_if, pbe_out_if and pbe_div.

// Each input beat gives a plane (Q2.14 normal, Q16.16 point) and a box; the block returns
// one beat per box edge that the plane crosses, in edge order 0..11, with last set on the
// final one, or a single empty_res beat when no edge is crossed. Two front stages form d,
// then an edge sequencer issues one edge per cycle, unless the result side stalls, into a
// shared pipelined divider (13 stages, four quotient bits each). An item occupies the
// sequencer through its last edge, and a new item is taken only when the sequencer is empty
// or on its last edge. The last hit of an item is held in the output formatter until the
// item end is known, while the next item's edges keep flowing. A stall on the result side
// holds the whole pipeline in place.
module plane_box_edge_intersect (
  input logic              clk,
  input logic              rst_n,
  pbe_in_if.sink           in_ch,
  pbe_out_if.source        out_ch
);

  localparam int CW    = pbe_pkg::CW;
  localparam int NW    = pbe_pkg::NW;
  localparam int PW    = pbe_pkg::PW;
  localparam int NUM_W = pbe_pkg::NUM_W;
  localparam int QW    = pbe_pkg::QW;
  localparam int EW    = pbe_pkg::EW;

  typedef struct packed {
    logic [2:0][NW-1:0] n;
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
  } geo_t;

  // Flow control.
  logic out_free;
  logic adv;
  logic f_adv;
  logic out_valid_r;
  logic pend_valid_r;
  logic pend_final_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign adv      = out_free;

  // Front stages: products of normal and point, then d.
  logic                 f1_valid_r;
  logic signed [PW-1:0] f1_px_r, f1_py_r, f1_pz_r;
  geo_t                 f1_geo_r;
  logic                 f2_valid_r;
  logic signed [NUM_W-1:0] f2_d_r;
  geo_t                 f2_geo_r;

  // Edge sequencer.
  logic                    seq_valid_r;
  logic [EW-1:0]           seq_edge_r;
  geo_t                    seq_geo_r;
  logic signed [NUM_W-1:0] seq_d_r;

  assign f_adv       = adv && (!seq_valid_r || seq_edge_r == pbe_pkg::LAST_EDGE);
  assign in_ch.ready = f_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (f_adv) begin
      f1_valid_r <= in_ch.valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      f1_px_r     <= PW'(in_ch.normal_x) * PW'(in_ch.point_x);
      f1_py_r     <= PW'(in_ch.normal_y) * PW'(in_ch.point_y);
      f1_pz_r     <= PW'(in_ch.normal_z) * PW'(in_ch.point_z);
      f1_geo_r.n  <= {in_ch.normal_z, in_ch.normal_y, in_ch.normal_x};
      f1_geo_r.lo <= {in_ch.box_lo_z, in_ch.box_lo_y, in_ch.box_lo_x};
      f1_geo_r.hi <= {in_ch.box_hi_z, in_ch.box_hi_y, in_ch.box_hi_x};
      f2_d_r      <= NUM_W'(f1_px_r) + NUM_W'(f1_py_r) + NUM_W'(f1_pz_r);
      f2_geo_r    <= f1_geo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
      seq_edge_r  <= '0;
    end else if (f_adv) begin
      seq_valid_r <= f2_valid_r;
      seq_edge_r  <= '0;
    end else if (adv && seq_valid_r) begin
      seq_edge_r <= seq_edge_r + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      seq_geo_r <= f2_geo_r;
      seq_d_r   <= f2_d_r;
    end
  end

  // Edge issue: pick the corner coordinates and the two fixed axes.
  logic [1:0]         iss_free;
  logic [2:0]         iss_sel;
  logic [1:0]         iss_a1, iss_a2;
  logic [2:0][CW-1:0] iss_v;

  always_comb begin
    iss_free = pbe_pkg::edge_free(seq_edge_r);
    iss_sel  = pbe_pkg::edge_sel(seq_edge_r);
    for (int i = 0; i < 3; i++) begin
      iss_v[i] = iss_sel[i] ? seq_geo_r.hi[i] : seq_geo_r.lo[i];
    end
    iss_a1 = (iss_free == pbe_pkg::AXIS_X) ? pbe_pkg::AXIS_Y : pbe_pkg::AXIS_X;
    iss_a2 = (iss_free == pbe_pkg::AXIS_Z) ? pbe_pkg::AXIS_Y : pbe_pkg::AXIS_Z;
  end

  // E1: the two products on the fixed axes.
  logic                    e1_valid_r;
  logic signed [PW-1:0]    e1_pa_r, e1_pb_r;
  logic signed [NUM_W-1:0] e1_d_r;
  logic signed [NW-1:0]    e1_nf_r;
  pbe_pkg::tag_t           e1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
    end else if (adv) begin
      e1_valid_r <= seq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_pa_r           <= PW'($signed(seq_geo_r.n[iss_a1])) * PW'($signed(iss_v[iss_a1]));
      e1_pb_r           <= PW'($signed(seq_geo_r.n[iss_a2])) * PW'($signed(iss_v[iss_a2]));
      e1_d_r            <= seq_d_r;
      e1_nf_r           <= seq_geo_r.n[iss_free];
      e1_tag_r.item_end <= (seq_edge_r == pbe_pkg::LAST_EDGE);
      e1_tag_r.skip     <= (seq_geo_r.n[iss_free] == '0);
      e1_tag_r.neg      <= 1'b0;
      e1_tag_r.edge_id  <= seq_edge_r;
      e1_tag_r.free     <= iss_free;
      e1_tag_r.vx       <= iss_v[0];
      e1_tag_r.vy       <= iss_v[1];
      e1_tag_r.vz       <= iss_v[2];
      e1_tag_r.lo_f     <= seq_geo_r.lo[iss_free];
      e1_tag_r.hi_f     <= seq_geo_r.hi[iss_free];
    end
  end

  // E2: numerator, then split into magnitudes and a quotient sign for the divider.
  logic signed [NUM_W-1:0] e2_num;
  logic [NUM_W-1:0]        e2_num_mag;
  logic [NW-1:0]           e2_den_mag;
  pbe_pkg::tag_t           e2_tag_nxt;
  logic                    e2_valid_r;
  logic [QW-1:0]           e2_num_r;
  logic [NW-1:0]           e2_den_r;
  pbe_pkg::tag_t           e2_tag_r;

  always_comb begin
    e2_num         = e1_d_r - NUM_W'(e1_pa_r) - NUM_W'(e1_pb_r);
    e2_num_mag     = e2_num[NUM_W-1] ? NUM_W'(-e2_num) : NUM_W'(e2_num);
    e2_den_mag     = e1_nf_r[NW-1] ? NW'(-e1_nf_r) : NW'(e1_nf_r);
    e2_tag_nxt     = e1_tag_r;
    e2_tag_nxt.neg = e2_num[NUM_W-1] ^ e1_nf_r[NW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_valid_r <= 1'b0;
    end else if (adv) begin
      e2_valid_r <= e1_valid_r;
    end
  end

  // A skipped edge still flows through, divided by one, so the item end is seen.
  always_ff @(posedge clk) begin
    if (adv) begin
      e2_num_r <= QW'(e2_num_mag);
      e2_den_r <= e1_tag_r.skip ? NW'(1) : e2_den_mag;
      e2_tag_r <= e2_tag_nxt;
    end
  end

  logic          dv_valid;
  logic [QW-1:0] dv_quot;
  pbe_pkg::tag_t dv_tag;

  pbe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (e2_valid_r),
    .in_num    (e2_num_r),
    .in_den    (e2_den_r),
    .in_tag    (e2_tag_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_tag   (dv_tag)
  );

  // E3: signed quotient and range check on the free axis.
  logic signed [QW-1:0] e3_q;
  pbe_pkg::res_t        e3_nxt;
  logic                 e3_valid_r;
  pbe_pkg::res_t        e3_r;

  always_comb begin
    e3_q            = dv_tag.neg ? -$signed(dv_quot) : $signed(dv_quot);
    e3_nxt.hit      = !dv_tag.skip && (e3_q >= QW'(dv_tag.lo_f)) && (e3_q <= QW'(dv_tag.hi_f));
    e3_nxt.item_end = dv_tag.item_end;
    e3_nxt.edge_id  = dv_tag.edge_id;
    e3_nxt.x        = (dv_tag.free == pbe_pkg::AXIS_X) ? e3_q[CW-1:0] : dv_tag.vx;
    e3_nxt.y        = (dv_tag.free == pbe_pkg::AXIS_Y) ? e3_q[CW-1:0] : dv_tag.vy;
    e3_nxt.z        = (dv_tag.free == pbe_pkg::AXIS_Z) ? e3_q[CW-1:0] : dv_tag.vz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_valid_r <= 1'b0;
    end else if (adv) begin
      e3_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_r <= e3_nxt;
    end
  end

  // Output formatter: one hit is held back until the next hit or the item end shows
  // whether it is the last one.
  pbe_pkg::res_t        pend_r;
  pbe_pkg::res_t        pend_nxt;
  logic                 pend_valid_nxt;
  logic                 pend_final_nxt;
  logic                 emit_nxt;
  logic signed [CW-1:0] emit_x, emit_y, emit_z;
  logic [EW-1:0]        emit_edge;
  logic                 emit_empty;
  logic                 emit_last;

  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [EW-1:0]        out_edge_r;
  logic                 out_empty_r;
  logic                 out_last_r;

  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    pend_final_nxt = pend_final_r;
    emit_nxt       = 1'b0;
    emit_x         = pend_r.x;
    emit_y         = pend_r.y;
    emit_z         = pend_r.z;
    emit_edge      = pend_r.edge_id;
    emit_empty     = 1'b0;
    emit_last      = 1'b0;
    if (adv && e3_valid_r && e3_r.hit) begin
      // A new hit pushes out the held one, which is final when it closed its item.
      emit_nxt       = pend_valid_r;
      emit_last      = pend_final_r;
      pend_nxt       = e3_r;
      pend_valid_nxt = 1'b1;
      pend_final_nxt = e3_r.item_end;
    end else if (adv && e3_valid_r && e3_r.item_end) begin
      emit_nxt       = 1'b1;
      emit_last      = 1'b1;
      pend_valid_nxt = 1'b0;
      pend_final_nxt = 1'b0;
      if (!pend_valid_r) begin
        emit_x     = '0;
        emit_y     = '0;
        emit_z     = '0;
        emit_edge  = '0;
        emit_empty = 1'b1;
      end
    end else if (pend_final_r && out_free) begin
      emit_nxt       = 1'b1;
      emit_last      = 1'b1;
      pend_valid_nxt = 1'b0;
      pend_final_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_final_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_final_r <= pend_final_nxt;
      if (out_free) begin
        out_valid_r <= emit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (out_free) begin
      out_x_r     <= emit_x;
      out_y_r     <= emit_y;
      out_z_r     <= emit_z;
      out_edge_r  <= emit_edge;
      out_empty_r <= emit_empty;
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit_x      = out_x_r;
  assign out_ch.hit_y      = out_y_r;
  assign out_ch.hit_z      = out_z_r;
  assign out_ch.edge_index = out_edge_r;
  assign out_ch.empty_res  = out_empty_r;
  assign out_ch.last       = out_last_r;

  a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_last_r && out_x_r == '0 && out_y_r == '0 &&
                                      out_z_r == '0 && out_edge_r == '0))
    else $error("empty result beat is not a zeroed final beat");

  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_empty_r) |-> (out_edge_r <= pbe_pkg::LAST_EDGE))
    else $error("result beat carries an edge number beyond the last edge");

  a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seq_valid_r |-> (seq_edge_r <= pbe_pkg::LAST_EDGE))
    else $error("edge sequencer ran past the last edge");

  a_final_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_final_r |-> pend_valid_r)
    else $error("final flag set with no held hit");

  a_final_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_final_r && out_free) |=> (out_valid_r && out_last_r && !pend_final_r))
    else $error("held final hit was not sent as the last beat");

endmodule

FILE: dv/testbench.sv
// Testbench for plane_box_edge_intersect: directed table, then random planes and boxes.
// Depends on pbe_pkg, pbe_in_if and pbe_out_if; the predictor computes edge hits in 64 bits.
module testbench;
  localparam int CW = pbe_pkg::CW;
  localparam int NW = pbe_pkg::NW;
  localparam int EW = pbe_pkg::EW;

  typedef struct {
    logic signed [NW-1:0] n [3];
    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
  } plane_box_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic [EW-1:0]        edge_id;
    logic                 empty_flag;
    logic                 last_flag;
  } hit_t;

  typedef struct {
    plane_box_t pb;
    bit         has_expect;
    hit_t       expect_hit;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  pbe_in_if  in_ch ();
  pbe_out_if out_ch ();

  plane_box_edge_intersect dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  hit_t pending_hits [$];
  hit_t typed_hits [$];
  int   error_count = 0;
  int   send_idle_pct = 26;
  int   recv_idle_pct = 72;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void add_expected(input hit_t h);
    pending_hits.insert(pending_hits.size(), h);
  endfunction

  // Which box corner each edge sits on per axis, and the axis it runs along.
  function automatic void edge_shape(input int e, output int free_axis, output bit sel [3]);
    free_axis = (e >= 8) ? 2 : (e % 2);
    sel[0] = (e == 1 || e == 5 || e == 9 || e == 11);
    sel[1] = (e == 2 || e == 6 || e == 10 || e == 11);
    sel[2] = (e >= 4 && e <= 7);
  endfunction

  function automatic void predict_hits(input plane_box_t pb);
    longint d, num, q, vv [3];
    int f, cnt;
    bit sel [3];
    hit_t h;
    d = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++) d += longint'(pb.n[i]) * longint'(pb.p[i]);
    for (int e = 0; e < 12; e++) begin
      edge_shape(e, f, sel);
      if (pb.n[f] == 0) continue;
      num = d;
      for (int i = 0; i < 3; i++) begin
        vv[i] = sel[i] ? longint'(pb.hi[i]) : longint'(pb.lo[i]);
        if (i != f) num -= longint'(pb.n[i]) * vv[i];
      end
      q = num / longint'(pb.n[f]);
      if (longint'(pb.lo[f]) <= q && q <= longint'(pb.hi[f])) begin
        vv[f] = q;
        h.x = vv[0][CW-1:0];
        h.y = vv[1][CW-1:0];
        h.z = vv[2][CW-1:0];
        h.edge_id = e[EW-1:0];
        h.empty_flag = 1'b0;
        h.last_flag = 1'b0;
        add_expected(h);
        cnt++;
      end
    end
    if (cnt == 0) begin
      h = '{0, 0, 0, '0, 1'b1, 1'b1};
      add_expected(h);
    end else begin
      pending_hits[$].last_flag = 1'b1;
    end
  endfunction

  function automatic plane_box_t random_item();
    plane_box_t pb;
    int mode;
    logic signed [CW-1:0] a, b;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (mode == 0) begin
        pb.n[i] = NW'($urandom);
        pb.p[i] = CW'($urandom);
        pb.lo[i] = CW'($urandom);
        pb.hi[i] = CW'($urandom);
      end else begin
        // Small boxes around a plane through a point near them give many hits.
        pb.n[i] = ($urandom_range(0, 7) == 0) ? '0 : NW'($urandom);
        a = $signed($urandom) >>> $urandom_range(1, 14);
        b = a + CW'($urandom_range(1, 32'h0004_0000));
        pb.lo[i] = a;
        pb.hi[i] = (mode == 1 && $urandom_range(0, 1)) ? a - 1 : b;
        pb.p[i] = a + CW'($urandom_range(0, 32'h0004_0000));
      end
    end
    if (mode == 2) pb.p = pb.lo;
    return pb;
  endfunction

  // Leaves valid high after the accepting edge; the caller drops it when it stops sending.
  task automatic send_item(input plane_box_t pb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.normal_x <= pb.n[0];
    in_ch.normal_y <= pb.n[1];
    in_ch.normal_z <= pb.n[2];
    in_ch.point_x <= pb.p[0];
    in_ch.point_y <= pb.p[1];
    in_ch.point_z <= pb.p[2];
    in_ch.box_lo_x <= pb.lo[0];
    in_ch.box_lo_y <= pb.lo[1];
    in_ch.box_lo_z <= pb.lo[2];
    in_ch.box_hi_x <= pb.hi[0];
    in_ch.box_hi_y <= pb.hi[1];
    in_ch.box_hi_z <= pb.hi[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_hits(pb);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_hits.pop_front();
        if (typed_hits.size() != 0 && typed_hits[0].edge_id == want.edge_id &&
            typed_hits[0].empty_flag == want.empty_flag)
          void'(typed_hits.pop_front());
        if (out_ch.hit_x !== want.x) report_mismatch("hit_x");
        if (out_ch.hit_y !== want.y) report_mismatch("hit_y");
        if (out_ch.hit_z !== want.z) report_mismatch("hit_z");
        if (out_ch.edge_index !== want.edge_id) report_mismatch("edge_index");
        if (out_ch.empty_res !== want.empty_flag) report_mismatch("empty_res");
        if (out_ch.last !== want.last_flag) report_mismatch("last");
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t r;
    plane_box_t pb;
    hit_t h;
    int wait_cycles;
    in_ch.valid = 1'b0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z} = '0;
    {in_ch.point_x, in_ch.point_y, in_ch.point_z} = '0;
    {in_ch.box_lo_x, in_ch.box_lo_y, in_ch.box_lo_z} = '0;
    {in_ch.box_hi_x, in_ch.box_hi_y, in_ch.box_hi_z} = '0;
    out_ch.ready = 1'b0;

    // All-zero normal: every edge is skipped, so one empty beat.
    r.pb = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
    r.has_expect = 1'b1;
    r.expect_hit = '{0, 0, 0, '0, 1'b1, 1'b1};
    rows.insert(rows.size(), r);
    // Plane x = 0 through a unit box at the origin: hits on each edge that runs along x.
    r.pb = '{'{16'sh4000, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{32'sh10000, 32'sh10000, 32'sh10000}};
    r.has_expect = 1'b0;
    rows.insert(rows.size(), r);
    // Plane far outside the box: one empty beat.
    r.pb = '{'{16'sh4000, 0, 0}, '{32'sh7fff0000, 0, 0}, '{0, 0, 0},
             '{32'sh10000, 32'sh10000, 32'sh10000}};
    r.has_expect = 1'b1;
    r.expect_hit = '{0, 0, 0, '0, 1'b1, 1'b1};
    rows.insert(rows.size(), r);
    // Inverted box on every axis.
    r.pb = '{'{16'sh2000, 16'sh2000, 16'sh2000}, '{0, 0, 0},
             '{32'sh10000, 32'sh10000, 32'sh10000}, '{0, 0, 0}};
    rows.insert(rows.size(), r);
    r.has_expect = 1'b0;
    // Extremes of every field.
    r.pb = '{'{16'sh8000, 16'sh8000, 16'sh8000},
             '{32'sh80000000, 32'sh80000000, 32'sh80000000},
             '{32'sh80000000, 32'sh80000000, 32'sh80000000},
             '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}};
    rows.insert(rows.size(), r);
    r.pb = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff},
             '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
             '{32'sh80000000, 32'sh80000000, 32'sh80000000},
             '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}};
    rows.insert(rows.size(), r);
    r.pb = '{'{16'sh7fff, 16'sh8000, 16'sh0001},
             '{32'sh80000000, 32'sh7fffffff, 32'shffffffff},
             '{32'sh80000000, 32'sh80000000, 32'sh80000000},
             '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}};
    rows.insert(rows.size(), r);
    // Diagonal plane through a corner: duplicate corner hits.
    r.pb = '{'{16'sh4000, 16'sh4000, 16'sh4000}, '{0, 0, 0}, '{0, 0, 0},
             '{32'sh10000, 32'sh10000, 32'sh10000}};
    rows.insert(rows.size(), r);
    // Planes normal to y and to z; then tilted with negative parts.
    r.pb = '{'{0, 16'shc000, 0}, '{0, 32'sh8000, 0}, '{0, 0, 0},
             '{32'sh10000, 32'sh10000, 32'sh10000}};
    rows.insert(rows.size(), r);
    r.pb = '{'{0, 0, 16'sh0001}, '{0, 0, 32'sh10000}, '{0, 0, 0},
             '{32'sh10000, 32'sh10000, 32'sh10000}};
    rows.insert(rows.size(), r);
    r.pb = '{'{16'sh1234, 16'shedcb, 16'sh3000}, '{32'sh8000, 32'sh4000, 32'shc000},
             '{32'shffff0000, 32'shffff0000, 32'shffff0000},
             '{32'sh20000, 32'sh20000, 32'sh20000}};
    rows.insert(rows.size(), r);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].has_expect) typed_hits.insert(typed_hits.size(), rows[k].expect_hit);
      send_item(rows[k].pb);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 26 : 0;
      for (int k = 0; k < 87; k++) begin
        if (k == 40) begin
          // Let the pipeline drain completely before the next beat.
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_hits.size() != 0) @(posedge clk);
        end
        send_item(random_item());
      end
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_hits.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (pending_hits.size() != 0) report_mismatch("expected results never arrived");
    if (typed_hits.size() != 0) report_mismatch("directed empty result not matched");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
